@@ design/cpa_pkg.sv @@
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and codes for the contiguous page allocator: status codes,
// operation and register codes, and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int CNT_FIELD_W  = 11;
    localparam int PAGE_FIELD_W = 10;
    localparam int CFG_W        = 11;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [0:0] REG_PAGES_IN_USE = 1'b0;
    localparam logic [0:0] REG_RESERVED     = 1'b1;

    localparam logic [CFG_W-1:0] PAGES_IN_USE_RST = 11'd1024;
    localparam logic [CFG_W-1:0] RESERVED_RST     = 11'd0;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_ZERO     = 3'd2,
        ST_RESERVED = 3'd3,
        ST_NOTSTART = 3'd4
    } status_t;

    typedef struct packed {
        logic    clr_step;
        logic    load_item;
        logic    scan_init;
        logic    scan_step;
        logic    mark_init;
        logic    mark_step;
        logic    free_rd;
        logic    free_init;
        logic    free_step;
        logic    set_code;
        status_t code;
        logic    out_load;
    } cpa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic cnt_zero;
        logic cnt_big;
        logic pg_rsv;
        logic pg_out;
        logic found;
        logic scan_end;
        logic mark_last;
        logic mark_rd;
        logic free_last;
        logic out_free;
    } cpa_stat_t;

endpackage

@@ design/cpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer for the page allocator: map clearing after reset, first-fit scan,
// run marking, run freeing and result hand-off.
// ----------------------------------------------------------------------------
module cpa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cpa_pkg::cpa_stat_t  stat,
    output cpa_pkg::cpa_cmd_t   cmd
);
    import cpa_pkg::*;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_MARK   = 8'b0001_0000,
        S_FWAIT  = 8'b0010_0000,
        S_FREE   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!stat.is_free) begin
                    if (stat.cnt_zero) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = ST_ZERO;
                        state_next   = S_DONE;
                    end else if (stat.cnt_big) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = ST_NOSPACE;
                        state_next   = S_DONE;
                    end else begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end else begin
                    if (stat.pg_rsv) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = ST_RESERVED;
                        state_next   = S_DONE;
                    end else if (stat.pg_out) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = ST_NOTSTART;
                        state_next   = S_DONE;
                    end else begin
                        cmd.free_rd = 1'b1;
                        state_next  = S_FWAIT;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.found) begin
                    cmd.mark_init = 1'b1;
                    state_next    = S_MARK;
                end else if (stat.scan_end) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_NOSPACE;
                    state_next   = S_DONE;
                end
            end
            S_MARK: begin
                cmd.mark_step = 1'b1;
                if (stat.mark_last) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_OK;
                    state_next   = S_DONE;
                end
            end
            S_FWAIT: begin
                if (!stat.mark_rd) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_NOTSTART;
                    state_next   = S_DONE;
                end else begin
                    cmd.free_init = 1'b1;
                    state_next    = S_FREE;
                end
            end
            S_FREE: begin
                cmd.free_step = 1'b1;
                if (stat.free_last) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_OK;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // one item in flight: no second accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item still in progress");
`endif

endmodule

@@ design/cpa_datapath.sv @@
// ----------------------------------------------------------------------------
// cpa_datapath
// Page map memories, configuration registers, scan/run counters and the
// result register of the page allocator.
// ----------------------------------------------------------------------------
module cpa_datapath #(
    parameter int MAP_PAGES = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_operation,
    input  logic [cpa_pkg::CNT_FIELD_W-1:0]       in_page_count,
    input  logic [cpa_pkg::PAGE_FIELD_W-1:0]      in_page_index,
    input  logic                                  cfg_valid,
    input  logic [0:0]                            cfg_index,
    input  logic [cpa_pkg::CFG_W-1:0]             cfg_data,
    input  cpa_pkg::cpa_cmd_t                     cmd,
    output cpa_pkg::cpa_stat_t                    stat,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output cpa_pkg::status_t                      m_status,
    output logic [cpa_pkg::PAGE_FIELD_W-1:0]      m_first_page
);
    import cpa_pkg::*;

    localparam int PG_W  = (MAP_PAGES > 1) ? $clog2(MAP_PAGES) : 1;
    localparam int CNT_W = $clog2(MAP_PAGES + 1);
    localparam int CW    = (CNT_W > CNT_FIELD_W) ? CNT_W : CNT_FIELD_W;
    localparam logic [PG_W-1:0] LAST_PAGE = PG_W'(MAP_PAGES - 1);

    logic [CFG_W-1:0]        pages_in_use_reg;
    logic [CFG_W-1:0]        reserved_reg;
    logic                    op_reg;
    logic [CNT_FIELD_W-1:0]  count_reg;
    logic [PAGE_FIELD_W-1:0] page_reg;
    logic [PG_W-1:0]         addr_reg;
    logic                    rd_vld_reg;
    logic [PG_W-1:0]         ev_addr_reg;
    logic [CW-1:0]           run_reg;
    logic [PG_W-1:0]         start_reg;
    logic [CW-1:0]           remain_reg;
    status_t                 code_reg;
    logic                    out_vld_reg;
    status_t                 out_status_reg;
    logic [PAGE_FIELD_W-1:0] out_start_reg;

    logic                    used_mem [MAP_PAGES];
    logic                    mark_mem [MAP_PAGES];
    logic [CNT_FIELD_W-1:0]  len_mem  [MAP_PAGES];
    logic                    used_rd;
    logic                    mark_rd;
    logic [CNT_FIELD_W-1:0]  len_rd;

    logic [CW-1:0]   limit;
    logic [CW-1:0]   count_ext;
    logic [CW-1:0]   page_ext;
    logic [CW-1:0]   rsv_ext;
    logic [CW-1:0]   ev_ext;
    logic [CW-1:0]   addr_ext;
    logic [CW-1:0]   run_inc;
    logic [PG_W-1:0] page_addr;
    logic [PG_W-1:0] rd_addr;
    logic [PG_W-1:0] start_cur;
    logic            issue;
    logic            busy;
    logic            found;
    logic            at_start;
    logic            at_page;
    logic            out_free;
    logic            used_we;
    logic            used_wd;
    logic            mark_we;
    logic            mark_wd;
    logic            len_we;

    always_comb begin
        limit     = (CW'(pages_in_use_reg) < CW'(MAP_PAGES)) ? CW'(pages_in_use_reg)
                                                             : CW'(MAP_PAGES);
        count_ext = CW'(count_reg);
        page_ext  = CW'(page_reg);
        rsv_ext   = CW'(reserved_reg);
        ev_ext    = CW'(ev_addr_reg);
        addr_ext  = CW'(addr_reg);
        run_inc   = run_reg + CW'(1);
        page_addr = PG_W'(page_reg);
        rd_addr   = cmd.free_rd ? page_addr : addr_reg;
        issue     = addr_ext < limit;
        busy      = (ev_ext < rsv_ext) || used_rd;
        found     = rd_vld_reg && !busy && (run_inc == count_ext);
        start_cur = (run_reg == '0) ? ev_addr_reg : start_reg;
        at_start  = addr_reg == start_reg;
        at_page   = addr_reg == page_addr;
        out_free  = !out_vld_reg || m_tready;

        used_we = cmd.clr_step || cmd.mark_step || cmd.free_step;
        used_wd = cmd.mark_step;
        mark_we = cmd.clr_step || cmd.mark_step || (cmd.free_step && at_page);
        mark_wd = cmd.mark_step && at_start;
        len_we  = cmd.mark_step && at_start;

        stat.clr_last  = addr_reg == LAST_PAGE;
        stat.is_free   = op_reg == OP_FREE;
        stat.cnt_zero  = count_reg == '0;
        stat.cnt_big   = count_ext > limit;
        stat.pg_rsv    = page_ext < rsv_ext;
        stat.pg_out    = page_ext >= limit;
        stat.found     = found;
        stat.scan_end  = rd_vld_reg && !found && (ev_ext == limit - CW'(1));
        stat.mark_last = remain_reg == CW'(1);
        stat.mark_rd   = mark_rd;
        stat.free_last = (remain_reg <= CW'(1)) || (addr_reg == LAST_PAGE);
        stat.out_free  = out_free;
    end

    // page map memories
    always_ff @(posedge aclk) begin
        if (used_we) begin
            used_mem[addr_reg] <= used_wd;
        end
        if (mark_we) begin
            mark_mem[addr_reg] <= mark_wd;
        end
        if (len_we) begin
            len_mem[addr_reg] <= count_reg;
        end
        used_rd <= used_mem[rd_addr];
        mark_rd <= mark_mem[rd_addr];
        len_rd  <= len_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pages_in_use_reg <= PAGES_IN_USE_RST;
            reserved_reg     <= RESERVED_RST;
            addr_reg         <= '0;
            rd_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_PAGES_IN_USE: pages_in_use_reg <= cfg_data;
                    REG_RESERVED:     reserved_reg     <= cfg_data;
                endcase
            end
            if (cmd.clr_step || cmd.mark_step || cmd.free_step) begin
                addr_reg <= addr_reg + PG_W'(1);
            end
            if (cmd.scan_init) begin
                addr_reg   <= '0;
                rd_vld_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                rd_vld_reg <= issue;
                if (issue) begin
                    addr_reg <= addr_reg + PG_W'(1);
                end
            end
            if (cmd.mark_init) begin
                addr_reg <= start_cur;
            end
            if (cmd.free_init) begin
                addr_reg <= page_addr;
            end
            if (cmd.out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= in_operation;
            count_reg <= in_page_count;
            page_reg  <= in_page_index;
        end
        if (cmd.scan_init) begin
            run_reg <= '0;
        end
        if (cmd.scan_step) begin
            ev_addr_reg <= addr_reg;
            if (rd_vld_reg) begin
                run_reg <= busy ? '0 : run_inc;
                if (!busy && (run_reg == '0)) begin
                    start_reg <= ev_addr_reg;
                end
            end
        end
        if (cmd.mark_init) begin
            remain_reg <= count_ext;
        end else if (cmd.free_init) begin
            remain_reg <= CW'(len_rd);
        end else if (cmd.mark_step || cmd.free_step) begin
            remain_reg <= remain_reg - CW'(1);
        end
        if (cmd.set_code) begin
            code_reg <= cmd.code;
        end
        if (cmd.out_load) begin
            out_status_reg <= code_reg;
            out_start_reg  <= (code_reg == ST_OK && op_reg == OP_ALLOC)
                              ? PAGE_FIELD_W'(start_reg) : '0;
        end
    end

    assign m_tvalid     = out_vld_reg;
    assign m_status     = out_status_reg;
    assign m_first_page = out_start_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register overwritten before it was taken");

    a_start_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_status_reg != ST_OK) |-> (out_start_reg == '0))
        else $error("nonzero start page on a failed item");

    a_remain_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mark_step || cmd.free_step) |-> (remain_reg != '0))
        else $error("run walk past its length");
`endif

endmodule

@@ design/contiguous_page_allocator_core.sv @@
// ----------------------------------------------------------------------------
// contiguous_page_allocator_core
// First-fit contiguous page allocator with run-start marks and a reserved
// region at the bottom of the page map.
//
//   channel  ports         direction  contents
//   s_       tdata/tuser   in         alloc/free request
//   m_       tdata/tuser   out        status and start page
//   cfg_     index/data    in         pages_in_use (0), reserved_pages (1)
//
// steps from accept to m_tvalid; a bad count or page ends after decode:
// allocate: decode, scan of up to MAP_PAGES pages, run marking
// free: decode, mark read, run walk; no run-start mark ends it at the read
// the scan and the run walk go one map entry per cycle through the map memory
// after reset a clearing pass over the whole page map runs before the first item
// a waiting result does not stop the next item from being taken
// ----------------------------------------------------------------------------
module contiguous_page_allocator_core #(
    parameter int MAP_PAGES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // page_count[10:0], page_index[20:11], zero pad
    input  logic [0:0]  s_tuser,    // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // first_page[9:0], zero pad
    output logic [2:0]  m_tuser,    // status[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import cpa_pkg::*;

    cpa_cmd_t                cmd;
    cpa_stat_t               stat;
    status_t                 out_status;
    logic [PAGE_FIELD_W-1:0] out_start;

    cpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cpa_datapath #(
        .MAP_PAGES (MAP_PAGES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_operation  (s_tuser[0]),
        .in_page_count (s_tdata[10:0]),
        .in_page_index (s_tdata[20:11]),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_status      (out_status),
        .m_first_page  (out_start)
    );

    assign cfg_ready = 1'b1;
    assign m_tuser   = out_status;
    assign m_tdata   = {6'b0, out_start};

endmodule
